### hdl/vcaff_pkg.sv
// Shared constants, codes and types of the first-free virtual-channel allocator.
`default_nettype none
package vcaff_pkg;

	// Router geometry
	localparam int NUM_DIRS     = 5;
	localparam int NUM_CHANNELS = 4;

	// Fixed field widths of the item ports
	localparam int DIR_W  = 3;
	localparam int CH_W   = 2;
	localparam int MASK_W = 4;

	// Index widths into the state arrays
	localparam int DIR_IDX_W = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;
	localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Operation codes
	localparam logic OP_CREDIT  = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef logic [NUM_CHANNELS-1:0] chan_vec_t;

	// Outcome of the channel search
	typedef struct packed {
		logic                found;
		logic [CH_IDX_W-1:0] idx;
		chan_vec_t           onehot;
	} pick_t;

endpackage
`default_nettype wire

### hdl/vcaff_pick.sv
// Lowest-free channel search with optional preference for non-congested channels.
`default_nettype none
module vcaff_pick (
	input  wire vcaff_pkg::chan_vec_t avail,
	input  wire vcaff_pkg::chan_vec_t congested,
	input  wire logic                 aware,
	output vcaff_pkg::pick_t          pick
);

	vcaff_pkg::chan_vec_t avail_nc;
	vcaff_pkg::chan_vec_t cand;
	vcaff_pkg::chan_vec_t oh;
	logic [vcaff_pkg::CH_IDX_W-1:0] idx;

	// Fall back to any free channel when no free channel is uncongested
	assign avail_nc = avail & ~congested;
	assign cand     = (aware && (|avail_nc)) ? avail_nc : avail;
	// Isolate the lowest set bit
	assign oh       = cand & (~cand + vcaff_pkg::chan_vec_t'(1));

	always_comb begin
		idx = '0;
		for (int i = 0; i < vcaff_pkg::NUM_CHANNELS; i++) begin
			if (oh[i]) begin
				idx = idx | vcaff_pkg::CH_IDX_W'(i);
			end
		end
	end

	assign pick.found  = |oh;
	assign pick.idx    = idx;
	assign pick.onehot = oh;

endmodule
`default_nettype wire

### hdl/vc_allocator_first_free.sv
// Top level of the first-free virtual-channel allocator for a router output stage.
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+---------------------------------------
//   input    | in  | in_valid / in_stall (out)    | operation, direction, channel_index,
//            |     |                              | channel_free, congested_mask
//   result   | out | out_valid / out_stall (in)   | found, granted_channel
//   config   | in  | cfg_valid / cfg_ready (out)  | cfg_wdata -> congestion_aware
//
// One item per cycle sustained while no request is held by a stalled result; a request passes
// the input register, then the result register. The search and the free-bit update sit between
// those registers, so back-to-back items on one direction see each other.
// Reset marks every channel of every direction free and clears congestion_aware.
// A stalled result holds in the result register; the input register keeps draining credit
// items and only holds a request while the result register is full and stalled.
`default_nettype none
module vc_allocator_first_free (
	input  wire  logic                        clk,
	input  wire  logic                        arst_n,

	input  wire  logic                        in_valid,
	output logic                              in_stall,
	input  wire  logic                        operation,
	input  wire  logic [vcaff_pkg::DIR_W-1:0] direction,
	input  wire  logic [vcaff_pkg::CH_W-1:0]  channel_index,
	input  wire  logic                        channel_free,
	input  wire  logic [vcaff_pkg::MASK_W-1:0] congested_mask,

	output logic                              out_valid,
	input  wire  logic                        out_stall,
	output logic                              found,
	output logic [vcaff_pkg::CH_W-1:0]        granted_channel,

	input  wire  logic                        cfg_valid,
	output logic                              cfg_ready,
	input  wire  logic                        cfg_wdata
);

	// Configuration
	logic congestion_aware_q;

	// Input register
	logic                              valid_s1;
	logic                              op_s1;
	logic [vcaff_pkg::DIR_W-1:0]       dir_s1;
	logic [vcaff_pkg::CH_W-1:0]        ch_s1;
	logic                              credit_s1;
	logic [vcaff_pkg::MASK_W-1:0]      mask_s1;

	// Free bits per direction
	vcaff_pkg::chan_vec_t free_q [vcaff_pkg::NUM_DIRS];

	// Result register
	logic                              out_valid_q;
	logic                              found_q;
	logic [vcaff_pkg::CH_W-1:0]        granted_q;

	// Stage control
	logic out_free;
	logic s1_retire;
	logic s1_load;
	logic res_load;

	// Datapath
	logic                                dir_ok;
	logic                                ch_ok;
	logic [vcaff_pkg::DIR_IDX_W-1:0]     dir_idx;
	logic [vcaff_pkg::CH_IDX_W-1:0]      ch_idx;
	vcaff_pkg::chan_vec_t                sel_free;
	vcaff_pkg::chan_vec_t                ch_bit;
	vcaff_pkg::chan_vec_t                cong;
	vcaff_pkg::chan_vec_t                next_free;
	logic                                upd_en;
	logic                                grant_ok;
	vcaff_pkg::pick_t                    pick;

	assign cfg_ready = 1'b1;

	// A credit item retires with no result; a request needs room in the result register
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_retire = valid_s1 && ((op_s1 == vcaff_pkg::OP_CREDIT) || out_free);
	assign s1_load   = in_valid && !in_stall;
	assign in_stall  = valid_s1 && !s1_retire;
	assign res_load  = s1_retire && (op_s1 == vcaff_pkg::OP_REQUEST);

	assign dir_ok  = 32'(dir_s1) < vcaff_pkg::NUM_DIRS;
	assign ch_ok   = 32'(ch_s1) < vcaff_pkg::NUM_CHANNELS;
	assign dir_idx = vcaff_pkg::DIR_IDX_W'(dir_s1);
	assign ch_idx  = vcaff_pkg::CH_IDX_W'(ch_s1);
	// Drop mask bits beyond the channel count
	assign cong    = vcaff_pkg::NUM_CHANNELS'(mask_s1);
	assign ch_bit  = vcaff_pkg::chan_vec_t'(1) << ch_idx;

	assign sel_free = dir_ok ? free_q[dir_idx] : '0;

	vcaff_pick u_pick (
		.avail     (sel_free),
		.congested (cong),
		.aware     (congestion_aware_q),
		.pick      (pick)
	);

	assign grant_ok = dir_ok && pick.found;

	always_comb begin
		next_free = sel_free;
		upd_en    = 1'b0;
		case (op_s1)
			vcaff_pkg::OP_CREDIT: begin
				// Ignore credits for a direction or channel that does not exist
				upd_en    = dir_ok && ch_ok;
				next_free = credit_s1 ? (sel_free | ch_bit) : (sel_free & ~ch_bit);
			end
			vcaff_pkg::OP_REQUEST: begin
				// Mark the granted channel busy
				upd_en    = grant_ok;
				next_free = sel_free & ~pick.onehot;
			end
			default: begin
				upd_en    = 1'b0;
				next_free = sel_free;
			end
		endcase
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			congestion_aware_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			congestion_aware_q <= cfg_wdata;
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= 1'b1;
		end else if (s1_retire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s1_load) begin
			op_s1     <= operation;
			dir_s1    <= direction;
			ch_s1     <= channel_index;
			credit_s1 <= channel_free;
			mask_s1   <= congested_mask;
		end
	end

	// Free bits: all channels free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < vcaff_pkg::NUM_DIRS; d++) begin
				free_q[d] <= '1;
			end
		end else if (s1_retire && upd_en) begin
			free_q[dir_idx] <= next_free;
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload; granted channel reads zero when nothing was free
	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q   <= grant_ok;
			granted_q <= grant_ok ? vcaff_pkg::CH_W'(pick.idx) : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign granted_channel = granted_q;

	// An empty result register never holds back the input
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled while result register empty");

	// A credit item never creates a result
	a_credit_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (op_s1 == vcaff_pkg::OP_CREDIT)) |=>
		(out_valid_q == $past(out_valid_q && out_stall)))
		else $error("credit item produced a result");

	// A granted channel is busy right after the grant
	a_grant_marks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && grant_ok) |=>
		((free_q[$past(dir_idx)] & $past(pick.onehot)) == '0))
		else $error("granted channel still marked free");

endmodule
`default_nettype wire

### verif/vcaff_grant_checker.sv
// Checker for the first-free virtual-channel allocator: predicts grants and compares results.
`default_nettype none
module vcaff_grant_checker (
	input  wire  logic                          clk,
	input  wire  logic                          arst_n,

	input  wire  logic                          in_valid,
	input  wire  logic                          in_stall,
	input  wire  logic                          operation,
	input  wire  logic [vcaff_pkg::DIR_W-1:0]  direction,
	input  wire  logic [vcaff_pkg::CH_W-1:0]   channel_index,
	input  wire  logic                          channel_free,
	input  wire  logic [vcaff_pkg::MASK_W-1:0] congested_mask,

	input  wire  logic                          out_valid,
	input  wire  logic                          out_stall,
	input  wire  logic                          found,
	input  wire  logic [vcaff_pkg::CH_W-1:0]   granted_channel,

	input  wire  logic                          cfg_valid,
	input  wire  logic                          cfg_ready,
	input  wire  logic                          cfg_wdata,

	output int                                  fail_count,
	output int                                  grants_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import vcaff_pkg::*;

	typedef struct packed {
		logic            found;
		logic [CH_W-1:0] channel;
	} grant_t;

	chan_vec_t free_map [NUM_DIRS];
	logic      prefer_uncongested;
	grant_t    grant_queue [$];

	function automatic int lowest_free(chan_vec_t bits);
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (bits[i])
				return i;
		end
		return -1;
	endfunction

	// Work out the grant of one request and mark the granted channel busy.
	function automatic grant_t predict_grant(logic [DIR_W-1:0] dir, logic [MASK_W-1:0] mask);
		chan_vec_t avail;
		chan_vec_t busy_mask;
		int        pick;
		grant_t    g;
		pick      = -1;
		busy_mask = '0;
		g         = '0;
		for (int i = 0; i < NUM_CHANNELS && i < MASK_W; i++)
			busy_mask[i] = mask[i];
		if (int'(dir) < NUM_DIRS) begin
			avail = free_map[dir];
			if (prefer_uncongested)
				pick = lowest_free(avail & ~busy_mask);
			if (pick < 0)
				pick = lowest_free(avail);
			if (pick >= 0)
				free_map[dir][pick] = 1'b0;
		end
		if (pick >= 0) begin
			g.found   = 1'b1;
			g.channel = CH_W'(pick);
		end
		return g;
	endfunction

	function automatic void apply_credit(logic [DIR_W-1:0] dir, logic [CH_W-1:0] ch,
					     logic credit);
		if (int'(dir) < NUM_DIRS && int'(ch) < NUM_CHANNELS)
			free_map[dir][ch] = credit;
	endfunction

	task automatic report_mismatch(input string what, input int wanted, input int seen);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, wanted, seen);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIRS; d++)
				free_map[d] = '1;
			prefer_uncongested = 1'b0;
			grant_queue.delete();
			fail_count = 0;
			grants_pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grant_queue.size() == 0) begin
					report_mismatch("result with no grant awaited, found", 0, int'(found));
				end else begin
					want = grant_queue.pop_front();
					if (found !== want.found)
						report_mismatch("found", int'(want.found), int'(found));
					if (granted_channel !== want.channel)
						report_mismatch("granted_channel", int'(want.channel),
								int'(granted_channel));
				end
			end
			if (cfg_valid && cfg_ready)
				prefer_uncongested = cfg_wdata;
			if (in_valid && !in_stall) begin
				if (operation == OP_REQUEST)
					grant_queue.push_back(predict_grant(direction, congested_mask));
				else
					apply_credit(direction, channel_index, channel_free);
			end
			grants_pending <= grant_queue.size();
		end
	end

endmodule
`default_nettype wire

### verif/tb_vc_allocator_first_free.sv
// Testbench top of the first-free virtual-channel allocator: stimulus, stalls and verdict.
`default_nettype none
module tb_vc_allocator_first_free;
	timeunit 1ns;
	timeprecision 1ps;

	import vcaff_pkg::*;

	// Settle time after the last awaited grant, before the mode register is written
	localparam int SETTLE_CYCLES = 8;
	// Length of the one long receiver hold-off that backs the block up
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 290;
	localparam int NUM_PHASES    = 6;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;

	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic                 operation      = OP_CREDIT;
	logic [DIR_W-1:0]     direction      = '0;
	logic [CH_W-1:0]      channel_index  = '0;
	logic                 channel_free   = 1'b0;
	logic [MASK_W-1:0]    congested_mask = '0;

	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic                 found;
	logic [CH_W-1:0]      granted_channel;

	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_wdata      = 1'b0;

	int                   fail_count;
	int                   grants_pending;

	// Stimulus asks for the long hold-off; the stall process times it
	logic                 hold_request   = 1'b0;
	// Calm stretch: no gaps from the sender and no stalls from the receiver
	logic                 calm           = 1'b0;

	always #10 clk = ~clk;

	vc_allocator_first_free u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.direction       (direction),
		.channel_index   (channel_index),
		.channel_free    (channel_free),
		.congested_mask  (congested_mask),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found           (found),
		.granted_channel (granted_channel),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_wdata       (cfg_wdata)
	);

	vcaff_grant_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.direction       (direction),
		.channel_index   (channel_index),
		.channel_free    (channel_free),
		.congested_mask  (congested_mask),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found           (found),
		.granted_channel (granted_channel),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.grants_pending  (grants_pending)
	);

	// Idle length: mostly none, often a few cycles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Receiver: random stall bursts, calm stretches, and one long hold-off on request.
	// The hold-off is counted here, cycle by cycle, while the sender keeps offering items.
	int  hold_left  = 0;
	int  burst_left = 0;
	logic hold_taken = 1'b0;

	always @(posedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall  <= 1'b0;
			burst_left = 0;
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < 30);
			burst_left = idle_len();
		end
	end

	// Offer one item and hold it until accepted; drop valid only if a gap follows,
	// so that back-to-back items keep valid high without a glitch.
	task automatic send_item(input logic op, input logic [DIR_W-1:0] dir,
				 input logic [CH_W-1:0] ch, input logic credit,
				 input logic [MASK_W-1:0] mask, input int gap);
		in_valid       <= 1'b1;
		operation      <= op;
		direction      <= dir;
		channel_index  <= ch;
		channel_free   <= credit;
		congested_mask <= mask;
		do
			@(posedge clk);
		while (in_stall);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_credit(input logic [DIR_W-1:0] dir, input logic [CH_W-1:0] ch,
				   input logic credit);
		send_item(OP_CREDIT, dir, ch, credit, MASK_W'($urandom), idle_len());
	endtask

	task automatic send_request(input logic [DIR_W-1:0] dir, input logic [MASK_W-1:0] mask);
		send_item(OP_REQUEST, dir, CH_W'($urandom), 1'($urandom), mask, idle_len());
	endtask

	// Mostly well-formed traffic on valid directions, credits leaning towards freeing
	// channels so that grants keep coming; a little noise over every field value.
	task automatic send_random();
		logic              op;
		logic [DIR_W-1:0]  dir;
		logic [CH_W-1:0]   ch;
		logic              credit;
		logic [MASK_W-1:0] mask;
		int                r;
		r    = $urandom_range(0, 99);
		mask = MASK_W'($urandom);
		ch   = CH_W'($urandom);
		dir  = DIR_W'($urandom_range(0, NUM_DIRS - 1));
		if (r < 6) begin
			dir    = DIR_W'($urandom);
			op     = 1'($urandom);
			credit = 1'($urandom);
		end else begin
			op     = (r < 56) ? OP_REQUEST : OP_CREDIT;
			credit = ($urandom_range(0, 3) != 0);
		end
		send_item(op, dir, ch, credit, mask, idle_len());
	endtask

	// Write the mode register; only called with the block idle
	task automatic write_mode(input logic aware);
		cfg_valid <= 1'b1;
		cfg_wdata <= aware;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every awaited grant, then let trailing credits settle
	task automatic settle_block();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (grants_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic mode;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Plain first-free mode: exhaust one direction, then free a channel again
		write_mode(1'b0);
		repeat (4) send_request(3'd0, 4'b0000);
		send_request(3'd0, 4'b0000);          // nothing left: not found
		send_credit(3'd0, 2'd2, 1'b1);
		send_request(3'd0, 4'b1111);          // mask has no say in this mode
		// Directions past the last one: credits ignored, requests never found
		send_credit(3'd7, 2'd0, 1'b0);
		send_request(3'd7, 4'b0000);
		send_request(3'd5, 4'b1111);
		send_credit(3'd6, 2'd3, 1'b1);
		// Occupy the top channel, request ignores index and credit value
		send_credit(3'd4, 2'd3, 1'b0);
		send_item(OP_REQUEST, 3'd4, 2'd3, 1'b1, 4'b0000, idle_len());
		settle_block();

		// Congestion-aware mode: prefer uncongested, fall back to any free channel
		write_mode(1'b1);
		send_request(3'd1, 4'b0001);          // skips congested channel 0
		send_request(3'd1, 4'b1111);          // all congested: lowest free
		send_request(3'd1, 4'b0110);
		send_request(3'd1, 4'b0000);
		send_request(3'd1, 4'b0000);          // exhausted
		send_credit(3'd1, 2'd3, 1'b1);
		send_credit(3'd1, 2'd1, 1'b1);
		send_request(3'd1, 4'b1000);
		send_credit(3'd2, 2'd1, 1'b0);
		send_request(3'd2, 4'b0001);
		settle_block();

		// Random phases across both settings; one phase backs the block up, one runs calm
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 4)
				mode = (p % 2 == 0);
			else
				mode = 1'($urandom);
			calm <= (p == 3);
			write_mode(mode);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 40)
					hold_request <= 1'b1;
				send_random();
			end
			settle_block();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
hdl/vcaff_pkg.sv
hdl/vcaff_pick.sv
hdl/vc_allocator_first_free.sv
verif/vcaff_grant_checker.sv
verif/tb_vc_allocator_first_free.sv
